// File: hdl/fda_pkg.sv
// ---------------------------------------------------------------------------
// fda_pkg
// Shared types and codes of the descriptor and file-entry allocator.
// ---------------------------------------------------------------------------
package fda_pkg;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_CLOSE  = 2'd2
  } func_e;

  // Status codes of a result word.
  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_BADF = 3'd1,
    ST_NOFD = 3'd2,
    ST_FULL = 3'd3,
    ST_ZERO = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_MAP  = 2'd1,
    SQ_CNT  = 2'd2
  } seq_e;

  // Width of one reference count.
  localparam int unsigned CntW = 8;

  // Control of the descriptor map.
  typedef struct packed {
    logic rd;   // read the entry link and valid bit of a slot
    logic wr;   // link a slot to an entry and mark it valid
    logic clr;  // mark a slot free
  } map_ctl_t;

  // Control of the reference-count memory.
  typedef struct packed {
    logic rd;
    logic wr;
  } cnt_ctl_t;

  // One result word.
  typedef struct packed {
    status_e    status;
    logic [3:0] fd;
    logic [5:0] entry;
    logic       last;
    logic [5:0] high_water;
  } result_t;

endpackage

// File: hdl/fda_slot_map.sv
// ---------------------------------------------------------------------------
// fda_slot_map
// Descriptor map: a memory of entry links, a valid bit per slot and a
// priority encoder that finds the lowest free slot.
// ---------------------------------------------------------------------------
module fda_slot_map
  import fda_pkg::*;
#(
  parameter int unsigned FD_SLOTS     = 16,
  parameter int unsigned FILE_ENTRIES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  map_ctl_t                        ctl_i,
  input  logic [$clog2(FD_SLOTS)-1:0]     addr_i,
  input  logic [$clog2(FILE_ENTRIES)-1:0] wdata_i,
  output logic [$clog2(FILE_ENTRIES)-1:0] rdata_o,
  output logic                            rvalid_o,
  output logic                            free_found_o,
  output logic [$clog2(FD_SLOTS)-1:0]     free_slot_o
);

  localparam int unsigned SW = $clog2(FD_SLOTS);
  localparam int unsigned EW = $clog2(FILE_ENTRIES);

  logic [EW-1:0]       mem_q [FD_SLOTS];
  logic [EW-1:0]       rdata_q;
  logic                rvalid_q;
  logic [FD_SLOTS-1:0] valid_q;
  logic [FD_SLOTS-1:0] valid_d;

  // Link memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // Valid bit of the slot being read, registered along with the link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (ctl_i.rd) begin
      rvalid_q <= valid_q[addr_i];
    end
  end

  // Slot valid bits; reset frees every slot at once.
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.wr) begin
      valid_d[addr_i] = 1'b1;
    end
    if (ctl_i.clr) begin
      valid_d[addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Lowest free slot.
  always_comb begin
    free_found_o = 1'b0;
    free_slot_o  = '0;
    for (int i = FD_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found_o = 1'b1;
        free_slot_o  = SW'(i);
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

// File: hdl/fda_ref_count.sv
// ---------------------------------------------------------------------------
// fda_ref_count
// Reference counts: a count memory, an in-use bit per entry that stands for
// a nonzero count, and a priority encoder for the lowest unused entry.
// ---------------------------------------------------------------------------
module fda_ref_count
  import fda_pkg::*;
#(
  parameter int unsigned FILE_ENTRIES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cnt_ctl_t                        ctl_i,
  input  logic [$clog2(FILE_ENTRIES)-1:0] addr_i,
  input  logic [CntW-1:0]                 wdata_i,
  output logic [CntW-1:0]                 rdata_o,
  output logic                            zero_found_o,
  output logic [$clog2(FILE_ENTRIES)-1:0] zero_ent_o
);

  localparam int unsigned EW = $clog2(FILE_ENTRIES);

  logic [CntW-1:0]         mem_q [FILE_ENTRIES];
  logic [CntW-1:0]         rdata_q;
  logic                    rbusy_q;
  logic [FILE_ENTRIES-1:0] busy_q;
  logic [FILE_ENTRIES-1:0] busy_d;

  // Count memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // In-use bit of the entry being read; a clear bit means the count is zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbusy_q <= 1'b0;
    end else if (ctl_i.rd) begin
      rbusy_q <= busy_q[addr_i];
    end
  end

  assign rdata_o = rbusy_q ? rdata_q : '0;

  // In-use bits follow every count write.
  always_comb begin
    busy_d = busy_q;
    if (ctl_i.wr) begin
      busy_d[addr_i] = (wdata_i != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Lowest entry whose count is zero.
  always_comb begin
    zero_found_o = 1'b0;
    zero_ent_o   = '0;
    for (int i = FILE_ENTRIES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        zero_found_o = 1'b1;
        zero_ent_o   = EW'(i);
      end
    end
  end

endmodule

// File: hdl/file_descriptor_allocator_unit.sv
// ---------------------------------------------------------------------------
// file_descriptor_allocator_unit
// Two-level allocator: a descriptor map over shared file entries with a
// reference count per entry and a high-water mark of allocated entries.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  func_i, fd_i
//  out      output     out_valid_o / out_stall_i status_o, fd_out_o, entry_out_o,
//                                               last_close_o, high_water_o
//
//  Allocate, look up and a bad descriptor pass the accept state and one
//  descriptor-map read. Close goes on to a count read and write-back of the
//  entry the map names, with no write-back if the count is already zero.
//  One word is in work at a time. Reset frees all slots and zeroes all counts at once; no clearing pass.
//  A stalled result holds the finished word in the sequencer until the output
//  register is free, while a waiting output word does not block acceptance.
// ---------------------------------------------------------------------------
module file_descriptor_allocator_unit
  import fda_pkg::*;
#(
  parameter int unsigned FD_SLOTS     = 16,
  parameter int unsigned FILE_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] fd_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [3:0] fd_out_o,
  output logic [5:0] entry_out_o,
  output logic       last_close_o,
  output logic [5:0] high_water_o
);

  localparam int unsigned SW = $clog2(FD_SLOTS);
  localparam int unsigned EW = $clog2(FILE_ENTRIES);

  seq_e            state_q, state_d;
  func_e           func_q;
  logic [7:0]      fd_q;
  logic [EW-1:0]   ent_q, ent_d;
  logic [EW-1:0]   highest_q, highest_d;
  logic            out_valid_q;
  result_t         res_q, res_d;
  logic            done;
  logic            out_free;
  logic            accept;
  logic            fd_bad;

  map_ctl_t        map_ctl;
  logic [SW-1:0]   map_addr;
  logic [EW-1:0]   map_wdata;
  logic [EW-1:0]   map_rdata;
  logic            map_rvalid;
  logic            free_found;
  logic [SW-1:0]   free_slot;

  cnt_ctl_t        cnt_ctl;
  logic [EW-1:0]   cnt_addr;
  logic [CntW-1:0] cnt_wdata;
  logic [CntW-1:0] cnt_rdata;
  logic [CntW-1:0] cnt_dec;
  logic            zero_found;
  logic [EW-1:0]   zero_ent;

  fda_slot_map #(
    .FD_SLOTS    (FD_SLOTS),
    .FILE_ENTRIES(FILE_ENTRIES)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (map_ctl),
    .addr_i      (map_addr),
    .wdata_i     (map_wdata),
    .rdata_o     (map_rdata),
    .rvalid_o    (map_rvalid),
    .free_found_o(free_found),
    .free_slot_o (free_slot)
  );

  fda_ref_count #(
    .FILE_ENTRIES(FILE_ENTRIES)
  ) u_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cnt_ctl),
    .addr_i      (cnt_addr),
    .wdata_i     (cnt_wdata),
    .rdata_o     (cnt_rdata),
    .zero_found_o(zero_found),
    .zero_ent_o  (zero_ent)
  );

  // Handshake terms.
  assign in_stall_o = (state_q != SQ_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_dec    = cnt_rdata - CntW'(1);

  // A descriptor is bad if the code is unused, it is out of range or free.
  assign fd_bad = (func_q != FN_LOOKUP && func_q != FN_CLOSE)
               || (9'(fd_q) >= 9'(FD_SLOTS)) || !map_rvalid;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          state_d = SQ_MAP;
        end
      end
      SQ_MAP: begin
        if (func_q == FN_CLOSE && !fd_bad) begin
          state_d = SQ_CNT;
        end else if (out_free) begin
          state_d = SQ_IDLE;
        end
      end
      SQ_CNT: begin
        if (out_free) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Memory accesses and the result word.
  always_comb begin
    map_ctl   = '0;
    map_addr  = fd_i[SW-1:0];
    map_wdata = zero_ent;
    cnt_ctl   = '0;
    cnt_addr  = zero_ent;
    cnt_wdata = CntW'(1);
    ent_d     = ent_q;
    highest_d = highest_q;
    done      = 1'b0;
    res_d     = '{status: ST_BADF, fd: fd_q[3:0], entry: '0, last: 1'b0,
                  high_water: 6'(highest_q)};
    unique case (state_q)
      SQ_IDLE: begin
        map_ctl.rd = accept;
      end
      SQ_MAP: begin
        if (func_q == FN_ALLOC) begin
          map_addr = free_slot;
          res_d.fd = 4'(free_slot);
          done     = out_free;
          if (!free_found) begin
            res_d.status = ST_NOFD;
            res_d.fd     = '0;
          end else if (!zero_found) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status = ST_OK;
            res_d.entry  = 6'(zero_ent);
            map_ctl.wr   = out_free;
            cnt_ctl.wr   = out_free;
            if (zero_ent > highest_q) begin
              highest_d = zero_ent;
            end
            res_d.high_water = 6'(highest_d);
          end
        end else if (fd_bad) begin
          done = out_free;
        end else if (func_q == FN_LOOKUP) begin
          res_d.status = ST_OK;
          res_d.entry  = 6'(map_rdata);
          done         = out_free;
        end else begin
          // Close: free the slot and fetch the entry's count.
          map_addr    = fd_q[SW-1:0];
          map_ctl.clr = 1'b1;
          cnt_addr    = map_rdata;
          cnt_ctl.rd  = 1'b1;
          ent_d       = map_rdata;
        end
      end
      SQ_CNT: begin
        cnt_addr    = ent_q;
        cnt_wdata   = cnt_dec;
        res_d.entry = 6'(ent_q);
        done        = out_free;
        if (cnt_rdata == '0) begin
          res_d.status = ST_ZERO;
        end else begin
          res_d.status = ST_OK;
          res_d.last   = (cnt_dec == '0);
          cnt_ctl.wr   = out_free;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // Sequencer and bookkeeping registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SQ_IDLE;
      highest_q <= '0;
    end else begin
      state_q <= state_d;
      if (done) begin
        highest_q <= highest_d;
      end
    end
  end

  // Captured input word and entry under close.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      fd_q   <= fd_i;
    end
    ent_q <= ent_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign fd_out_o     = res_q.fd;
  assign entry_out_o  = res_q.entry;
  assign last_close_o = res_q.last;
  assign high_water_o = res_q.high_water;

  // The count stage is reached only by a close.
  a_cnt_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SQ_CNT |-> func_q == FN_CLOSE)
    else $error("count stage entered without a close");

  // The high-water mark never falls.
  a_hw_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> highest_q >= $past(highest_q))
    else $error("high-water mark decreased");

  // A last-reference flag comes only with a good close.
  a_last_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_close_o |-> status_o == ST_OK)
    else $error("last close flagged on an error result");

  // A result is finished only while the output register can take it.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_free)
    else $error("result overwrote a stalled word");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the descriptor and file-entry allocator. A tracker
// keeps its own copy of the descriptor map, the reference counts and the
// high-water mark, predicts one result word per accepted input word and
// compares every accepted result against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import fda_pkg::*;

  localparam int unsigned FdSlots     = 16;
  localparam int unsigned FileEntries = 64;
  localparam int unsigned ItemsPerPhase = 400;

  // Operation code that the block does not define.
  localparam logic [1:0] FnUnused = 2'd3;

  // Tracks the allocator state and the result words still owed by the block.
  class fd_table_tracker;
    bit         slot_live [FdSlots];
    logic [5:0] slot_link [FdSlots];
    logic [7:0] entry_refs [FileEntries];
    logic [5:0] top_entry;
    result_t    replies_due [$];
    int         failures;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i] = 1'b0;
        slot_link[i] = '0;
      end
      foreach (entry_refs[i]) entry_refs[i] = '0;
      top_entry = '0;
      failures  = 0;
    endfunction

    // Predict the result of one accepted input word and update the state.
    function void note_request(logic [1:0] op, logic [7:0] fd);
      result_t    r;
      int         slot;
      int         ent;
      logic [3:0] s;
      r    = '0;
      slot = -1;
      ent  = -1;
      s    = fd[3:0];
      if (op == FN_ALLOC) begin
        for (int i = 0; i < FdSlots; i++) begin
          if (!slot_live[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          r.status = ST_NOFD;
        end else begin
          for (int j = 0; j < FileEntries; j++) begin
            if (entry_refs[j] == 0) begin
              ent = j;
              break;
            end
          end
          r.fd = slot[3:0];
          if (ent < 0) begin
            r.status = ST_FULL;
          end else begin
            entry_refs[ent] = 8'd1;
            slot_live[slot] = 1'b1;
            slot_link[slot] = ent[5:0];
            if (ent[5:0] > top_entry) top_entry = ent[5:0];
            r.status = ST_OK;
            r.entry  = ent[5:0];
          end
        end
      end else if (op == FnUnused || fd >= FdSlots || !slot_live[s]) begin
        r.status = ST_BADF;
        r.fd     = s;
      end else begin
        r.fd    = s;
        r.entry = slot_link[s];
        if (op == FN_LOOKUP) begin
          r.status = ST_OK;
        end else begin
          // Close frees the slot even when the count is already zero.
          slot_live[s] = 1'b0;
          slot_link[s] = '0;
          if (entry_refs[r.entry] == 0) begin
            r.status = ST_ZERO;
          end else begin
            entry_refs[r.entry] = entry_refs[r.entry] - 8'd1;
            r.status = ST_OK;
            r.last   = (entry_refs[r.entry] == 0);
          end
        end
      end
      r.high_water = top_entry;
      replies_due.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    // Check one accepted result word against the oldest prediction.
    function void check_reply(logic [2:0] status, logic [3:0] fd, logic [5:0] entry,
                              logic last, logic [5:0] high_water);
      result_t w;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d fd %0d",
                 $time, status, fd);
        failures++;
      end else begin
        w = replies_due.pop_front();
        compare("status", w.status, status);
        compare("fd_out", w.fd, fd);
        compare("entry_out", w.entry, entry);
        compare("last_close", w.last, last);
        compare("high_water", w.high_water, high_water);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] func_i;
  logic [7:0] fd_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic [3:0] fd_out_o;
  logic [5:0] entry_out_o;
  logic       last_close_o;
  logic [5:0] high_water_o;

  int unsigned sender_gap_pct;
  int unsigned sink_stall_pct;

  fd_table_tracker tracker = new();

  file_descriptor_allocator_unit #(
    .FD_SLOTS    (FdSlots),
    .FILE_ENTRIES(FileEntries)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .fd_i        (fd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .fd_out_o    (fd_out_o),
    .entry_out_o (entry_out_o),
    .last_close_o(last_close_o),
    .high_water_o(high_water_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #2ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: check accepted words and pick the next stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_reply(status_o, fd_out_o, entry_out_o, last_close_o, high_water_o);
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < sink_stall_pct);
  end

  // Present one word after an optional random gap and hold it until accepted.
  task automatic send_word(input logic [1:0] op, input logic [7:0] fd);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    fd_i       <= fd;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    tracker.note_request(op, fd);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.replies_due.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int unsigned alloc_pct;
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  fd;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FN_ALLOC;
    fd_i           = '0;
    out_stall_i    = 1'b0;
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: free descriptors, filling the map, range edges, unused code.
    send_word(FN_LOOKUP, 8'd0);
    send_word(FN_CLOSE, 8'd255);
    for (int i = 0; i <= FdSlots; i++) send_word(FN_ALLOC, 8'($urandom_range(255)));
    send_word(FN_LOOKUP, 8'd0);
    send_word(FN_LOOKUP, 8'd15);
    send_word(FN_LOOKUP, 8'd16);
    send_word(FnUnused, 8'd3);
    send_word(FnUnused, 8'd255);
    send_word(FN_CLOSE, 8'd7);
    send_word(FN_CLOSE, 8'd7);
    send_word(FN_ALLOC, 8'd255);
    send_word(FN_CLOSE, 8'd15);
    drain_results();

    // Random phases with different amounts of idling on both sides.
    alloc_pct = 40;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 49;
          sink_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          sink_stall_pct = 49;
        end
        default: begin
          sender_gap_pct = 36;
          sink_stall_pct = 36;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Swing the allocate share so the map runs both full and empty.
        if (n % 50 == 0) alloc_pct = 20 * $urandom_range(1, 3);
        pick = $urandom_range(99);
        if (pick < alloc_pct) op = FN_ALLOC;
        else if (pick < alloc_pct + (96 - alloc_pct) / 2) op = FN_LOOKUP;
        else if (pick < 96) op = FN_CLOSE;
        else op = FnUnused;
        if ($urandom_range(99) < 85) fd = 8'($urandom_range(FdSlots - 1));
        else fd = 8'($urandom_range(255));
        send_word(op, fd);
        if ($urandom_range(63) == 0) drain_results();
      end
      drain_results();
    end

    // Let any stray word surface before the verdict.
    repeat (16) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.replies_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: file_descriptor_allocator_unit.f
hdl/fda_pkg.sv
hdl/fda_slot_map.sv
hdl/fda_ref_count.sv
hdl/file_descriptor_allocator_unit.sv
sim/testbench.sv
